// ===== hdl/ild_pkg.sv =====
// Package for the row-major 3D index unit: codes, default widths and the
// control struct passed along the cell chain. No dependencies.
package ild_pkg;

    localparam int COORD_BITS_DEF = 16;

    // Register index width and register codes on the configuration channel
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAYERS = 2'd2;

    // Item kinds
    localparam logic KIND_LIN   = 1'b0;
    localparam logic KIND_DELIN = 1'b1;

    // Control part of an item as it moves between stages
    typedef struct packed {
        logic valid;
        logic kind;
        logic err;
    } ild_ctrl_t;

endpackage

// ===== hdl/ild_cell.sv =====
// One cell of the chain: a shift-and-add multiply step or a restoring
// divide step on one digit bit. Depends on ild_pkg.
module ild_cell
    import ild_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int BIT        = 0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  ild_ctrl_t                 ctrl_i,
    input  logic [3*COORD_BITS-1:0]   acc_i,
    input  logic [2*COORD_BITS-1:0]   opnd_i,
    input  logic [COORD_BITS-1:0]     dig_i,
    input  logic [COORD_BITS-1:0]     aux_a_i,
    input  logic [COORD_BITS-1:0]     aux_b_i,
    output ild_ctrl_t                 ctrl_o,
    output logic [3*COORD_BITS-1:0]   acc_o,
    output logic [2*COORD_BITS-1:0]   opnd_o,
    output logic [COORD_BITS-1:0]     dig_o,
    output logic [COORD_BITS-1:0]     aux_a_o,
    output logic [COORD_BITS-1:0]     aux_b_o
);

    localparam int LW = 3 * COORD_BITS;

    ild_ctrl_t               ctrl_reg;
    logic [LW-1:0]           acc_reg;
    logic [LW-1:0]           acc_next;
    logic [2*COORD_BITS-1:0] opnd_reg;
    logic [COORD_BITS-1:0]   dig_reg;
    logic [COORD_BITS-1:0]   dig_next;
    logic [COORD_BITS-1:0]   aux_a_reg;
    logic [COORD_BITS-1:0]   aux_b_reg;

    logic [LW-1:0]           shifted;
    logic [LW:0]             diff;

    assign shifted = LW'(opnd_i) << BIT;
    assign diff    = {1'b0, acc_i} - {1'b0, shifted};

    always_comb
    begin
        acc_next = acc_i;
        dig_next = dig_i;
        if (ctrl_i.kind == KIND_LIN)
        begin
            // add the shifted multiplicand where the multiplier bit is set
            if (dig_i[BIT])
            begin
                acc_next = acc_i + shifted;
            end
        end
        else if (!diff[LW])
        begin
            // no borrow: keep the difference and set the quotient bit
            acc_next      = diff[LW-1:0];
            dig_next[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (load)
        begin
            ctrl_reg <= ctrl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            acc_reg   <= acc_next;
            opnd_reg  <= opnd_i;
            dig_reg   <= dig_next;
            aux_a_reg <= aux_a_i;
            aux_b_reg <= aux_b_i;
        end
    end

    assign ctrl_o  = ctrl_reg;
    assign acc_o   = acc_reg;
    assign opnd_o  = opnd_reg;
    assign dig_o   = dig_reg;
    assign aux_a_o = aux_a_reg;
    assign aux_b_o = aux_b_reg;

endmodule

// ===== hdl/ild_bridge.sv =====
// Stage between the two halves of the chain: adds the row for linearize,
// checks the layer and sets up the second divide for delinearize.
// Depends on ild_pkg.
module ild_bridge
    import ild_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic [COORD_BITS-1:0]     dim_cols,
    input  logic [COORD_BITS-1:0]     dim_layers,
    input  ild_ctrl_t                 ctrl_i,
    input  logic [3*COORD_BITS-1:0]   acc_i,
    input  logic [COORD_BITS-1:0]     dig_i,
    input  logic [COORD_BITS-1:0]     aux_a_i,
    input  logic [COORD_BITS-1:0]     aux_b_i,
    output ild_ctrl_t                 ctrl_o,
    output logic [3*COORD_BITS-1:0]   acc_o,
    output logic [2*COORD_BITS-1:0]   opnd_o,
    output logic [COORD_BITS-1:0]     dig_o,
    output logic [COORD_BITS-1:0]     aux_a_o,
    output logic [COORD_BITS-1:0]     aux_b_o
);

    localparam int LW = 3 * COORD_BITS;
    localparam int PW = 2 * COORD_BITS;

    ild_ctrl_t             ctrl_reg;
    ild_ctrl_t             ctrl_next;
    logic [LW-1:0]         acc_reg;
    logic [LW-1:0]         acc_next;
    logic [PW-1:0]         opnd_reg;
    logic [PW-1:0]         opnd_next;
    logic [COORD_BITS-1:0] dig_reg;
    logic [COORD_BITS-1:0] dig_next;
    logic [COORD_BITS-1:0] aux_a_reg;
    logic [COORD_BITS-1:0] aux_a_next;
    logic [COORD_BITS-1:0] aux_b_reg;

    always_comb
    begin
        ctrl_next  = ctrl_i;
        acc_next   = acc_i;
        opnd_next  = PW'(dim_cols);
        dig_next   = '0;
        aux_a_next = aux_a_i;
        if (ctrl_i.kind == KIND_LIN)
        begin
            // layer*rows + row becomes the multiplicand, cols the multiplier
            opnd_next = acc_i[PW-1:0] + PW'(aux_a_i);
            acc_next  = '0;
            dig_next  = dim_cols;
        end
        else
        begin
            // quotient of the first divide is the layer
            ctrl_next.err = ctrl_i.err | (dig_i >= dim_layers);
            aux_a_next    = dig_i;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (load)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            acc_reg   <= acc_next;
            opnd_reg  <= opnd_next;
            dig_reg   <= dig_next;
            aux_a_reg <= aux_a_next;
            aux_b_reg <= aux_b_i;
        end
    end

    assign ctrl_o  = ctrl_reg;
    assign acc_o   = acc_reg;
    assign opnd_o  = opnd_reg;
    assign dig_o   = dig_reg;
    assign aux_a_o = aux_a_reg;
    assign aux_b_o = aux_b_reg;

endmodule

// ===== hdl/index_linearize_delinearize_top.sv =====
// Top level of the row-major 3D index unit: configuration registers,
// input and setup stages, two rows of ild_cell joined by ild_bridge, output
// register. Depends on ild_pkg, ild_cell, ild_bridge.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+-----------------------------------------------
//   cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//   in      | in  | in_valid / in_stall   | kind, col_in, row_in, layer_in, linear_in
//   out     | out | out_valid / out_stall | linear_out, col_out, row_out, layer_out, range_err
//
// One item enters per cycle while in_stall is low; each of the two rows holds
// COORD_BITS cells, one digit bit per cell.
// Reset clears the valid bit of every stage and sets the extents to 1.
// Stages hold while the stage after them is full and held; a bubble anywhere
// in the chain lets the stages behind it advance, so in_stall only rises
// when every stage holds an item and the output is stalled.
// Configuration writes are taken at once (cfg_ready is tied high).
module index_linearize_delinearize_top
    import ild_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_BITS-1:0]     cfg_data,
    // input items
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      kind,
    input  logic [COORD_BITS-1:0]     col_in,
    input  logic [COORD_BITS-1:0]     row_in,
    input  logic [COORD_BITS-1:0]     layer_in,
    input  logic [3*COORD_BITS-1:0]   linear_in,
    // result items
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [3*COORD_BITS-1:0]   linear_out,
    output logic [COORD_BITS-1:0]     col_out,
    output logic [COORD_BITS-1:0]     row_out,
    output logic [COORD_BITS-1:0]     layer_out,
    output logic                      range_err
);

    localparam int CB  = COORD_BITS;
    localparam int LW  = 3 * CB;
    localparam int PW  = 2 * CB;
    localparam int NST = 2 * CB + 4;    // input, setup, CB cells, bridge, CB cells, output
    localparam int BRIDGE_ST = CB + 2;
    localparam int OUT_ST    = NST - 1;

    // ------------------------------------------------------------------
    // Configuration registers and the plane size derived from them
    // ------------------------------------------------------------------
    logic [CB-1:0] dim_cols_reg;
    logic [CB-1:0] dim_rows_reg;
    logic [CB-1:0] dim_layers_reg;
    logic [PW-1:0] plane_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_cols_reg   <= CB'(1);
            dim_rows_reg   <= CB'(1);
            dim_layers_reg <= CB'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COLS:   dim_cols_reg   <= cfg_data;
                REG_ROWS:   dim_rows_reg   <= cfg_data;
                REG_LAYERS: dim_layers_reg <= cfg_data;
                default:    ;   // drop writes beyond the register list
            endcase
        end
    end

    // Recompute every cycle; it settles in the cycle after a write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= PW'(1);
        end
        else
        begin
            plane_reg <= PW'(dim_rows_reg) * PW'(dim_cols_reg);
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its item moves on
    // ------------------------------------------------------------------
    logic [NST-1:0] st_valid;
    logic [NST-1:0] st_load;

    assign st_load[OUT_ST] = !st_valid[OUT_ST] || !out_stall;

    genvar g;
    generate
        for (g = 0; g < OUT_ST; g++)
        begin : g_load
            assign st_load[g] = !st_valid[g] || st_load[g+1];
        end
    endgenerate

    assign in_stall = !st_load[0];

    // ------------------------------------------------------------------
    // Input stage: capture the item as it arrives
    // ------------------------------------------------------------------
    ild_ctrl_t     in_ctrl_reg;
    logic [CB-1:0] in_col_reg;
    logic [CB-1:0] in_row_reg;
    logic [CB-1:0] in_layer_reg;
    logic [LW-1:0] in_lin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctrl_reg <= '0;
        end
        else if (st_load[0])
        begin
            in_ctrl_reg.valid <= in_valid;
            in_ctrl_reg.kind  <= kind;
            in_ctrl_reg.err   <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_load[0])
        begin
            in_col_reg   <= col_in;
            in_row_reg   <= row_in;
            in_layer_reg <= layer_in;
            in_lin_reg   <= linear_in;
        end
    end

    assign st_valid[0] = in_ctrl_reg.valid;

    // ------------------------------------------------------------------
    // Setup stage: bounds checks and operands for the first row of cells.
    // Linearize multiplies layer by rows; delinearize divides the index by
    // the plane size. An index at or above plane << CB would give a layer
    // wider than CB bits and is out of range anyway.
    // ------------------------------------------------------------------
    ild_ctrl_t     su_ctrl_next;
    logic [LW-1:0] su_acc_next;
    logic [PW-1:0] su_opnd_next;
    logic [CB-1:0] su_dig_next;

    ild_ctrl_t     su_ctrl_reg;
    logic [LW-1:0] su_acc_reg;
    logic [PW-1:0] su_opnd_reg;
    logic [CB-1:0] su_dig_reg;
    logic [CB-1:0] su_row_reg;
    logic [CB-1:0] su_col_reg;

    always_comb
    begin
        su_ctrl_next = in_ctrl_reg;
        if (in_ctrl_reg.kind == KIND_LIN)
        begin
            su_ctrl_next.err = (in_col_reg >= dim_cols_reg)
                             | (in_row_reg >= dim_rows_reg)
                             | (in_layer_reg >= dim_layers_reg);
            su_acc_next      = '0;
            su_opnd_next     = PW'(in_layer_reg);
            su_dig_next      = dim_rows_reg;
        end
        else
        begin
            su_ctrl_next.err = (plane_reg == '0)
                             | (in_lin_reg >= {plane_reg, {CB{1'b0}}});
            su_acc_next      = in_lin_reg;
            su_opnd_next     = plane_reg;
            su_dig_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            su_ctrl_reg <= '0;
        end
        else if (st_load[1])
        begin
            su_ctrl_reg <= su_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_load[1])
        begin
            su_acc_reg  <= su_acc_next;
            su_opnd_reg <= su_opnd_next;
            su_dig_reg  <= su_dig_next;
            su_row_reg  <= in_row_reg;
            su_col_reg  <= in_col_reg;
        end
    end

    assign st_valid[1] = su_ctrl_reg.valid;

    // ------------------------------------------------------------------
    // First row of cells, most significant digit bit first
    // ------------------------------------------------------------------
    ild_ctrl_t     a_ctrl  [0:CB];
    logic [LW-1:0] a_acc   [0:CB];
    logic [PW-1:0] a_opnd  [0:CB];
    logic [CB-1:0] a_dig   [0:CB];
    logic [CB-1:0] a_aux_a [0:CB];
    logic [CB-1:0] a_aux_b [0:CB];

    assign a_ctrl[0]  = su_ctrl_reg;
    assign a_acc[0]   = su_acc_reg;
    assign a_opnd[0]  = su_opnd_reg;
    assign a_dig[0]   = su_dig_reg;
    assign a_aux_a[0] = su_row_reg;
    assign a_aux_b[0] = su_col_reg;

    generate
        for (g = 0; g < CB; g++)
        begin : g_row_a
            ild_cell #(
                .COORD_BITS (CB),
                .BIT        (CB - 1 - g)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .load    (st_load[2+g]),
                .ctrl_i  (a_ctrl[g]),
                .acc_i   (a_acc[g]),
                .opnd_i  (a_opnd[g]),
                .dig_i   (a_dig[g]),
                .aux_a_i (a_aux_a[g]),
                .aux_b_i (a_aux_b[g]),
                .ctrl_o  (a_ctrl[g+1]),
                .acc_o   (a_acc[g+1]),
                .opnd_o  (a_opnd[g+1]),
                .dig_o   (a_dig[g+1]),
                .aux_a_o (a_aux_a[g+1]),
                .aux_b_o (a_aux_b[g+1])
            );
            assign st_valid[2+g] = a_ctrl[g+1].valid;
        end
    endgenerate

    // ------------------------------------------------------------------
    // Bridge: row add or layer check, then setup of the second row
    // ------------------------------------------------------------------
    ild_ctrl_t     b_ctrl  [0:CB];
    logic [LW-1:0] b_acc   [0:CB];
    logic [PW-1:0] b_opnd  [0:CB];
    logic [CB-1:0] b_dig   [0:CB];
    logic [CB-1:0] b_aux_a [0:CB];
    logic [CB-1:0] b_aux_b [0:CB];

    ild_bridge #(
        .COORD_BITS (CB)
    ) u_bridge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (st_load[BRIDGE_ST]),
        .dim_cols   (dim_cols_reg),
        .dim_layers (dim_layers_reg),
        .ctrl_i     (a_ctrl[CB]),
        .acc_i      (a_acc[CB]),
        .dig_i      (a_dig[CB]),
        .aux_a_i    (a_aux_a[CB]),
        .aux_b_i    (a_aux_b[CB]),
        .ctrl_o     (b_ctrl[0]),
        .acc_o      (b_acc[0]),
        .opnd_o     (b_opnd[0]),
        .dig_o      (b_dig[0]),
        .aux_a_o    (b_aux_a[0]),
        .aux_b_o    (b_aux_b[0])
    );

    assign st_valid[BRIDGE_ST] = b_ctrl[0].valid;

    // ------------------------------------------------------------------
    // Second row of cells: multiply by cols, or divide the remainder by cols
    // ------------------------------------------------------------------
    generate
        for (g = 0; g < CB; g++)
        begin : g_row_b
            ild_cell #(
                .COORD_BITS (CB),
                .BIT        (CB - 1 - g)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .load    (st_load[BRIDGE_ST+1+g]),
                .ctrl_i  (b_ctrl[g]),
                .acc_i   (b_acc[g]),
                .opnd_i  (b_opnd[g]),
                .dig_i   (b_dig[g]),
                .aux_a_i (b_aux_a[g]),
                .aux_b_i (b_aux_b[g]),
                .ctrl_o  (b_ctrl[g+1]),
                .acc_o   (b_acc[g+1]),
                .opnd_o  (b_opnd[g+1]),
                .dig_o   (b_dig[g+1]),
                .aux_a_o (b_aux_a[g+1]),
                .aux_b_o (b_aux_b[g+1])
            );
            assign st_valid[BRIDGE_ST+1+g] = b_ctrl[g+1].valid;
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output register: add the column for linearize, pick the triple for
    // delinearize, zero everything on a range error.
    // ------------------------------------------------------------------
    ild_ctrl_t     fin_ctrl;
    logic          fin_lin_ok;
    logic          fin_del_ok;

    logic          out_valid_reg;
    logic [LW-1:0] linear_out_reg;
    logic [CB-1:0] col_out_reg;
    logic [CB-1:0] row_out_reg;
    logic [CB-1:0] layer_out_reg;
    logic          range_err_reg;

    assign fin_ctrl   = b_ctrl[CB];
    assign fin_lin_ok = !fin_ctrl.err && (fin_ctrl.kind == KIND_LIN);
    assign fin_del_ok = !fin_ctrl.err && (fin_ctrl.kind == KIND_DELIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (st_load[OUT_ST])
        begin
            out_valid_reg <= fin_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_load[OUT_ST])
        begin
            linear_out_reg <= fin_lin_ok ? (b_acc[CB] + LW'(b_aux_b[CB])) : '0;
            col_out_reg    <= fin_del_ok ? b_acc[CB][CB-1:0] : '0;
            row_out_reg    <= fin_del_ok ? b_dig[CB] : '0;
            layer_out_reg  <= fin_del_ok ? b_aux_a[CB] : '0;
            range_err_reg  <= fin_ctrl.err;
        end
    end

    assign st_valid[OUT_ST] = out_valid_reg;

    assign out_valid  = out_valid_reg;
    assign linear_out = linear_out_reg;
    assign col_out    = col_out_reg;
    assign row_out    = row_out_reg;
    assign layer_out  = layer_out_reg;
    assign range_err  = range_err_reg;

endmodule

// ===== tb/sv/tb_index_linearize_delinearize_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the row-major 3D index unit: directed table, then random phases.
// Depends on ild_pkg and index_linearize_delinearize_top; needs nothing else.
module tb_index_linearize_delinearize_top;
    import ild_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 150;
    localparam int TAIL_CYCLES = 2 * CB + 8;       // a little past the pipeline depth
    localparam int TIMEOUT_NS  = 5_000_000;        // far past any clean run

    // index 3 decodes to no register; writes there must not land anywhere
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic          kind;
        logic [CB-1:0] col;
        logic [CB-1:0] row;
        logic [CB-1:0] layer;
        logic [3*CB-1:0] linear;
    } index_req_t;

    typedef struct packed {
        logic [3*CB-1:0] linear;
        logic [CB-1:0]   col;
        logic [CB-1:0]   row;
        logic [CB-1:0]   layer;
        logic            err;
    } index_res_t;

    // Directed table: a DIMS row reloads the extents (col/row/layer columns carry them),
    // a TYPED row carries its expected result, a PREDICTED row goes through the model.
    typedef enum logic [1:0] {ROW_DIMS, ROW_TYPED, ROW_PREDICTED} row_op_t;

    typedef struct packed {
        row_op_t         op;
        logic [CB-1:0]   col;
        logic [CB-1:0]   row;
        logic [CB-1:0]   layer;
        logic            kind;
        logic [3*CB-1:0] linear;
        logic [3*CB-1:0] x_linear;
        logic [CB-1:0]   x_col;
        logic [CB-1:0]   x_row;
        logic [CB-1:0]   x_layer;
        logic            x_err;
    } dir_row_t;

    typedef enum int {DIMS_UNIT, DIMS_MAX, DIMS_SMALL, DIMS_WIDE, DIMS_SKEWED, DIMS_EMPTY}
        dims_mode_t;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_mode_t;

    localparam int N_DIR = 28;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        // extents at reset are 1 x 1 x 1: only the origin is inside
        '{ROW_TYPED, 0, 0, 0, KIND_LIN, 0, 0, 0, 0, 0, 0},
        '{ROW_TYPED, 1, 0, 0, KIND_LIN, 0, 0, 0, 0, 0, 1},
        '{ROW_TYPED, 0, 0, 0, KIND_DELIN, 0, 0, 0, 0, 0, 0},
        '{ROW_TYPED, 0, 0, 0, KIND_DELIN, 1, 0, 0, 0, 0, 1},
        '{ROW_TYPED, 16'hFFFF, 16'hFFFF, 16'hFFFF, KIND_LIN, 48'hFFFFFFFFFFFF, 0, 0, 0, 0, 1},
        // largest grid: the far corner needs the full 48-bit product
        '{ROW_DIMS, 16'hFFFF, 16'hFFFF, 16'hFFFF, KIND_LIN, 0, 0, 0, 0, 0, 0},
        '{ROW_TYPED, 16'hFFFE, 16'hFFFE, 16'hFFFE, KIND_LIN, 0, 48'hFFFD0002FFFE, 0, 0, 0, 0},
        '{ROW_TYPED, 0, 0, 0, KIND_DELIN, 48'hFFFD0002FFFE, 0, 16'hFFFE, 16'hFFFE, 16'hFFFE, 0},
        '{ROW_TYPED, 0, 0, 0, KIND_DELIN, 48'hFFFD0002FFFF, 0, 0, 0, 0, 1},
        '{ROW_TYPED, 0, 0, 0, KIND_DELIN, 48'hFFFFFFFFFFFF, 0, 0, 0, 0, 1},
        '{ROW_TYPED, 16'hFFFF, 0, 0, KIND_LIN, 0, 0, 0, 0, 0, 1},
        // the unused operand fields must not leak into the result
        '{ROW_TYPED, 0, 0, 0, KIND_LIN, 48'hFFFFFFFFFFFF, 0, 0, 0, 0, 0},
        '{ROW_TYPED, 16'hFFFF, 16'hFFFF, 16'hFFFF, KIND_DELIN, 0, 0, 0, 0, 0, 0},
        '{ROW_PREDICTED, 1234, 5, 77, KIND_LIN, 0, 0, 0, 0, 0, 0},
        '{ROW_PREDICTED, 0, 0, 0, KIND_DELIN, 48'h123456789ABC, 0, 0, 0, 0, 0},
        // odd small grid, edges on every axis
        '{ROW_DIMS, 7, 5, 3, KIND_LIN, 0, 0, 0, 0, 0, 0},
        '{ROW_PREDICTED, 6, 4, 2, KIND_LIN, 0, 0, 0, 0, 0, 0},
        '{ROW_PREDICTED, 0, 0, 0, KIND_DELIN, 104, 0, 0, 0, 0, 0},
        '{ROW_TYPED, 0, 0, 0, KIND_DELIN, 105, 0, 0, 0, 0, 1},
        '{ROW_TYPED, 0, 5, 0, KIND_LIN, 0, 0, 0, 0, 0, 1},
        '{ROW_TYPED, 0, 0, 3, KIND_LIN, 0, 0, 0, 0, 0, 1},
        // a zero extent on any axis leaves nothing in range
        '{ROW_DIMS, 0, 5, 3, KIND_LIN, 0, 0, 0, 0, 0, 0},
        '{ROW_TYPED, 0, 0, 0, KIND_LIN, 0, 0, 0, 0, 0, 1},
        '{ROW_TYPED, 0, 0, 0, KIND_DELIN, 0, 0, 0, 0, 0, 1},
        '{ROW_DIMS, 5, 0, 3, KIND_LIN, 0, 0, 0, 0, 0, 0},
        '{ROW_TYPED, 0, 0, 0, KIND_DELIN, 0, 0, 0, 0, 0, 1},
        '{ROW_DIMS, 5, 3, 0, KIND_LIN, 0, 0, 0, 0, 0, 0},
        '{ROW_TYPED, 0, 0, 0, KIND_LIN, 0, 0, 0, 0, 0, 1}
    };

    // DUT signals; every input starts at a known value
    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CB-1:0]     cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic              kind      = KIND_LIN;
    logic [CB-1:0]     col_in    = '0;
    logic [CB-1:0]     row_in    = '0;
    logic [CB-1:0]     layer_in  = '0;
    logic [3*CB-1:0]   linear_in = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [3*CB-1:0]   linear_out;
    logic [CB-1:0]     col_out;
    logic [CB-1:0]     row_out;
    logic [CB-1:0]     layer_out;
    logic              range_err;

    // Bench copy of the extents, updated when a write is taken
    logic [CB-1:0] ext_cols   = 1;
    logic [CB-1:0] ext_rows   = 1;
    logic [CB-1:0] ext_layers = 1;

    index_res_t  pending_results [$];
    int unsigned mismatch_count = 0;
    int unsigned burst_left     = 0;

    stall_mode_t stall_mode    = STALL_NONE;
    int unsigned stall_left    = 0;
    logic [15:0] stall_pattern = '0;

    index_linearize_delinearize_top #(
        .COORD_BITS (CB)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .col_in     (col_in),
        .row_in     (row_in),
        .layer_in   (layer_in),
        .linear_in  (linear_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .linear_out (linear_out),
        .col_out    (col_out),
        .row_out    (row_out),
        .layer_out  (layer_out),
        .range_err  (range_err)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // Row-major conversion at full width. Bounds are checked first; a zero extent
    // makes the volume zero, so every delinearize fails before any division.
    function automatic index_res_t convert_index(input index_req_t q);
        logic [63:0] plane;
        logic [63:0] volume;
        logic [63:0] idx;
        logic [63:0] layer_q;
        logic [63:0] rem;
        index_res_t  res;
        res    = '0;
        plane  = 64'(ext_rows) * 64'(ext_cols);
        volume = 64'(ext_layers) * plane;
        if (q.kind == KIND_LIN)
        begin
            if (q.col >= ext_cols || q.row >= ext_rows || q.layer >= ext_layers)
                res.err = 1'b1;
            else
                res.linear = (3*CB)'(64'(q.layer) * plane + 64'(q.row) * 64'(ext_cols)
                                     + 64'(q.col));
        end
        else
        begin
            idx = 64'(q.linear);
            if (idx >= volume)
                res.err = 1'b1;
            else
            begin
                layer_q   = idx / plane;
                rem       = idx - layer_q * plane;
                res.layer = CB'(layer_q);
                res.row   = CB'(rem / 64'(ext_cols));
                res.col   = CB'(rem % 64'(ext_cols));
            end
        end
        return res;
    endfunction

    // Mostly in-range operands so the arithmetic gets exercised; one in ten sits on
    // an edge (last valid point or one past it) and one in five is fully random.
    function automatic index_req_t random_request();
        index_req_t  q;
        logic [63:0] volume;
        int unsigned pick;
        volume   = 64'(ext_cols) * 64'(ext_rows) * 64'(ext_layers);
        q.kind   = 1'($urandom_range(0, 1));
        q.col    = CB'($urandom);
        q.row    = CB'($urandom);
        q.layer  = CB'($urandom);
        q.linear = (3*CB)'({$urandom, $urandom});
        pick     = $urandom_range(0, 9);
        if (pick < 8 && volume != 0)
        begin
            if (q.kind == KIND_LIN)
            begin
                q.col   = CB'($urandom_range(0, ext_cols - 1));
                q.row   = CB'($urandom_range(0, ext_rows - 1));
                q.layer = CB'($urandom_range(0, ext_layers - 1));
                if (pick == 7)
                begin
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            q.col   = ext_cols - 1'b1;
                            q.row   = ext_rows - 1'b1;
                            q.layer = ext_layers - 1'b1;
                        end
                        1:       q.col   = ext_cols;
                        2:       q.row   = ext_rows;
                        default: q.layer = ext_layers;
                    endcase
                end
            end
            else if (pick == 7)
                q.linear = (3*CB)'($urandom_range(0, 1) ? volume - 1 : volume);
            else
                q.linear = (3*CB)'(64'({$urandom, $urandom}) % volume);
        end
        return q;
    endfunction

    function automatic void check_field(input string name, input logic [3*CB-1:0] want,
                                        input logic [3*CB-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // Hold the item until taken, queue its expectation, then pace the next one:
    // bursts of random length, a random gap after each, now and then a long run.
    task automatic send_item(input index_req_t req, input index_res_t want, input bit last);
        int unsigned gap;
        in_valid  <= 1'b1;
        kind      <= req.kind;
        col_in    <= req.col;
        row_in    <= req.row;
        layer_in  <= req.layer;
        linear_in <= req.linear;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(want);
        if (last)
            in_valid <= 1'b0;
        else if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // Leaves cfg_valid high; load_extents drops it once the batch is done
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CB-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_COLS:   ext_cols   = value;
            REG_ROWS:   ext_rows   = value;
            REG_LAYERS: ext_layers = value;
            default:    ;
        endcase
    endtask

    // Reload all three extents, then poke the spare index with junk
    task automatic load_extents(input logic [CB-1:0] cols, input logic [CB-1:0] rows,
                                input logic [CB-1:0] layers);
        write_reg(REG_COLS, cols);
        write_reg(REG_ROWS, rows);
        write_reg(REG_LAYERS, layers);
        write_reg(REG_SPARE, CB'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: switch stall behavior after each random stretch, including
    // stretches with no stall at all.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode    = stall_mode_t'($urandom_range(STALL_NONE, STALL_PATTERN));
                stall_left    = $urandom_range(16, 256);
                stall_pattern = 16'($urandom);
            end
            else
                stall_left--;
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
                default:     out_stall <= stall_pattern[stall_left % 16];
            endcase
        end
    end

    // Result checker: every taken result is matched against the oldest expectation
    always @(posedge clk)
    begin : result_check
        index_res_t got;
        index_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{linear_out, col_out, row_out, layer_out, range_err};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("linear_out", want.linear, got.linear);
                check_field("col_out", 48'(want.col), 48'(got.col));
                check_field("row_out", 48'(want.row), 48'(got.row));
                check_field("layer_out", 48'(want.layer), 48'(got.layer));
                check_field("range_err", 48'(want.err), 48'(got.err));
            end
        end
    end

    initial
    begin
        index_req_t    req;
        index_res_t    want;
        dir_row_t      dr;
        dims_mode_t    mode;
        logic [CB-1:0] d_cols;
        logic [CB-1:0] d_rows;
        logic [CB-1:0] d_layers;
        bit            last;

        // hold reset, then release it on an edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Extents change only once everything in flight is back.
        for (int i = 0; i < N_DIR; i++)
        begin
            dr = DIR_ROWS[i];
            if (dr.op == ROW_DIMS)
            begin
                wait_idle();
                load_extents(dr.col, dr.row, dr.layer);
            end
            else
            begin
                req = '{dr.kind, dr.col, dr.row, dr.layer, dr.linear};
                if (dr.op == ROW_TYPED)
                    want = '{dr.x_linear, dr.x_col, dr.x_row, dr.x_layer, dr.x_err};
                else
                    want = convert_index(req);
                // drop valid before a reload or at the end of the table
                last = (i == N_DIR - 1) ? 1'b1 : (DIR_ROWS[i + 1].op == ROW_DIMS);
                send_item(req, want, last);
            end
        end

        // Random phases: the first six walk every grid shape once, the rest
        // favor small, wide and skewed grids where most operands land inside.
        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_idle();
            if (p < 6)
                mode = dims_mode_t'(p);
            else
                mode = dims_mode_t'($urandom_range(DIMS_SMALL, DIMS_SKEWED));
            d_cols   = CB'($urandom_range(1, 8));
            d_rows   = CB'($urandom_range(1, 8));
            d_layers = CB'($urandom_range(1, 8));
            case (mode)
                DIMS_UNIT:
                begin
                    d_cols   = 1;
                    d_rows   = 1;
                    d_layers = 1;
                end
                DIMS_MAX:
                begin
                    d_cols   = '1;
                    d_rows   = '1;
                    d_layers = '1;
                end
                DIMS_SMALL: ;
                DIMS_WIDE:
                begin
                    d_cols   = CB'($urandom_range(1, 65535));
                    d_rows   = CB'($urandom_range(1, 65535));
                    d_layers = CB'($urandom_range(1, 65535));
                end
                DIMS_SKEWED:
                begin
                    case ($urandom_range(0, 2))
                        0:       d_cols   = '1;
                        1:       d_rows   = '1;
                        default: d_layers = '1;
                    endcase
                end
                default:
                begin
                    // one empty axis: everything must come back out of range
                    case ($urandom_range(0, 2))
                        0:       d_cols   = '0;
                        1:       d_rows   = '0;
                        default: d_layers = '0;
                    endcase
                end
            endcase
            load_extents(d_cols, d_rows, d_layers);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                req = random_request();
                send_item(req, convert_index(req), k == PHASE_ITEMS - 1);
            end
        end

        // drain, then linger past the pipeline depth to catch stray results
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
